>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define TPP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tap pulse player assertion failed");

// Check that a condition never holds outside reset.
`define TPP_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tap pulse player forbidden condition seen");

`endif

>>> rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// Tape pulse player package
// Payload structs, request and command codes, and sequencer states.
// ----------------------------------------------------------------------------
package tpp_pkg;

   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_ADVANCE = 2'd1;
   localparam logic [1:0] REQ_CONTROL = 2'd2;
   localparam logic [1:0] REQ_STATUS  = 2'd3;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_PLAY   = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_REWIND = 2'd3;

   localparam logic CSR_TAP_VERSION = 1'b0;
   localparam logic CSR_ZERO_GAP    = 1'b1;

   localparam logic [23:0] ZERO_GAP_RESET = 24'd2500;
   localparam logic [2:0]  EDGE_MAX       = 3'd7;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tape_byte;
      logic       last_byte;
      logic [7:0] cycles;
      logic [1:0] command;
      logic       motor_level;
   } tpp_req_type;

   typedef struct packed {
      logic       byte_accepted;
      logic [2:0] edges;
      logic       starved;
      logic [7:0] cycles_left;
      logic       running;
      logic       playing;
   } tpp_rsp_type;

   typedef struct packed {
      logic [7:0]  cyc_next;
      logic [23:0] rem_next;
      logic        gap_done;
   } step_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADVANCE,
      ST_POP,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/tap_pulse_player.sv
// ----------------------------------------------------------------------------
// Tape pulse player
// Decodes tape payload bytes into gaps, queues them and plays them out as
// pulses against advance requests, under play, stop, rewind and motor control.
// ----------------------------------------------------------------------------
// Byte, control and status requests go from idle through execute to finish,
// where the result is registered. An advance goes from execute to the advance
// state for each compare-and-subtract step and to the pop state for each gap
// fetched from the queue head; one transfer is handled at a time, and a new
// request transfers while the previous result still waits in its register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tap_pulse_player import tpp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tpp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tpp_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);

   state_type        state_ff, state_in;
   tpp_req_type      req_ff, req_in;
   tpp_rsp_type      rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       tap_version_ff;
   logic [23:0]      zero_gap_ff;
   logic [23:0]      rem_ff, rem_in;
   logic [7:0]       cyc_ff, cyc_in;
   logic [2:0]       edges_ff, edges_in;
   logic             starved_ff, starved_in;
   logic [7:0]       left_ff, left_in;
   logic             accepted_ff, accepted_in;
   logic [23:0]      long_val_ff, long_val_in;
   logic [1:0]       long_phase_ff, long_phase_in;
   logic             end_seen_ff, end_seen_in;
   logic             play_ff, play_in;
   logic             motor_ff, motor_in;

   logic             q_push, q_pop, q_clear;
   logic [23:0]      q_push_data, q_head;
   queue_status_type q_status;
   step_result_type  step;
   logic [23:0]      zero_gap_eff;
   logic [23:0]      long_full;
   logic             running_now;
   logic             adv_go;

   tpp_gap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .clear     (q_clear),
      .head_data (q_head),
      .status    (q_status)
   );

   tpp_step_unit u_step (
      .cyc    (cyc_ff),
      .rem    (rem_ff),
      .result (step)
   );

   assign zero_gap_eff = (zero_gap_ff == 24'd0) ? 24'd1 : zero_gap_ff;
   assign long_full    = {long_val_ff[23:16] | req_ff.tape_byte, long_val_ff[15:0]};
   assign running_now  = play_ff && motor_ff &&
                         ((rem_ff != 24'd0) || !q_status.empty || !end_seen_ff);
   assign adv_go       = (cyc_ff != 8'd0) && running_now;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = (req_ff.req_type == REQ_ADVANCE) ? ST_ADVANCE : ST_FINISH;
         end
         ST_ADVANCE: begin
            if (!adv_go || (rem_ff == 24'd0 && q_status.empty)) begin
               state_in = ST_FINISH;
            end else if (rem_ff == 24'd0) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_ADVANCE;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      q_push        = 1'b0;
      q_pop         = 1'b0;
      q_clear       = 1'b0;
      q_push_data   = 24'd0;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rem_in        = rem_ff;
      cyc_in        = cyc_ff;
      edges_in      = edges_ff;
      starved_in    = starved_ff;
      left_in       = left_ff;
      accepted_in   = accepted_ff;
      long_val_in   = long_val_ff;
      long_phase_in = long_phase_ff;
      end_seen_in   = end_seen_ff;
      play_in       = play_ff;
      motor_in      = motor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in      = req_data;
               cyc_in      = req_data.cycles;
               edges_in    = 3'd0;
               starved_in  = 1'b0;
               left_in     = 8'd0;
               accepted_in = 1'b0;
            end
         end
         ST_EXEC: begin
            case (req_ff.req_type)
               REQ_BYTE: begin
                  if (!q_status.full && !end_seen_ff) begin
                     accepted_in = 1'b1;
                     if (long_phase_ff == 2'd1) begin
                        long_val_in[7:0] = long_val_ff[7:0] | req_ff.tape_byte;
                        long_phase_in    = 2'd2;
                     end else if (long_phase_ff == 2'd2) begin
                        long_val_in[15:8] = long_val_ff[15:8] | req_ff.tape_byte;
                        long_phase_in     = 2'd3;
                     end else if (long_phase_ff == 2'd3) begin
                        q_push        = 1'b1;
                        q_push_data   = (long_full != 24'd0) ? long_full : zero_gap_eff;
                        long_phase_in = 2'd0;
                        long_val_in   = 24'd0;
                     end else if (req_ff.tape_byte != 8'd0) begin
                        q_push      = 1'b1;
                        q_push_data = {13'd0, req_ff.tape_byte, 3'd0};
                     end else if (tap_version_ff == 2'd0) begin
                        q_push      = 1'b1;
                        q_push_data = zero_gap_eff;
                     end else begin
                        long_phase_in = 2'd1;
                        long_val_in   = 24'd0;
                     end
                     if (req_ff.last_byte) begin
                        end_seen_in   = 1'b1;
                        long_phase_in = 2'd0;
                        long_val_in   = 24'd0;
                     end
                  end
               end
               REQ_CONTROL: begin
                  motor_in = req_ff.motor_level;
                  case (req_ff.command)
                     CMD_PLAY: begin
                        if (!q_status.empty || !end_seen_ff) begin
                           play_in = 1'b1;
                        end
                     end
                     CMD_STOP: begin
                        play_in = 1'b0;
                     end
                     CMD_REWIND: begin
                        play_in       = 1'b0;
                        rem_in        = 24'd0;
                        q_clear       = 1'b1;
                        long_phase_in = 2'd0;
                        long_val_in   = 24'd0;
                        end_seen_in   = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         ST_ADVANCE: begin
            if (adv_go) begin
               if (rem_ff == 24'd0) begin
                  if (q_status.empty) begin
                     if (end_seen_ff) begin
                        play_in = 1'b0;
                     end else begin
                        starved_in = 1'b1;
                        left_in    = cyc_ff;
                     end
                  end
               end else begin
                  cyc_in = step.cyc_next;
                  rem_in = step.rem_next;
                  if (step.gap_done) begin
                     if (edges_ff != EDGE_MAX) begin
                        edges_in = edges_ff + 3'd1;
                     end
                     if (q_status.empty && end_seen_ff) begin
                        play_in = 1'b0;
                     end
                  end
               end
            end
         end
         ST_POP: begin
            rem_in = q_head;
            q_pop  = 1'b1;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.byte_accepted = accepted_ff;
               rsp_in.edges         = edges_ff;
               rsp_in.starved       = starved_ff;
               rsp_in.cycles_left   = left_ff;
               rsp_in.running       = running_now;
               rsp_in.playing       = play_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         tap_version_ff <= 2'd0;
         zero_gap_ff    <= ZERO_GAP_RESET;
         rem_ff         <= 24'd0;
         long_val_ff    <= 24'd0;
         long_phase_ff  <= 2'd0;
         end_seen_ff    <= 1'b0;
         play_ff        <= 1'b0;
         motor_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rem_ff        <= rem_in;
         long_val_ff   <= long_val_in;
         long_phase_ff <= long_phase_in;
         end_seen_ff   <= end_seen_in;
         play_ff       <= play_in;
         motor_ff      <= motor_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TAP_VERSION: tap_version_ff <= csr_wdata[1:0];
               CSR_ZERO_GAP:    zero_gap_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      cyc_ff      <= cyc_in;
      edges_ff    <= edges_in;
      starved_ff  <= starved_in;
      left_ff     <= left_in;
      accepted_ff <= accepted_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TPP_NEVER(a_push_when_full, q_push && q_status.full)
   `TPP_NEVER(a_pop_when_empty, q_pop && q_status.empty)
   `TPP_ASSERT(a_accept_to_exec, (req_valid && req_ready) |=> (state_ff == ST_EXEC))
   `TPP_ASSERT(a_starved_has_left, (rsp_valid && rsp_data.starved) |-> (rsp_data.cycles_left != 8'd0))

endmodule

>>> rtl/tpp_step_unit.sv
// ----------------------------------------------------------------------------
// Tape pulse player step unit
// One compare and subtract: spends the lesser of the cycles and the gap left.
// ----------------------------------------------------------------------------
module tpp_step_unit import tpp_pkg::*; (
   input  logic [7:0]      cyc,
   input  logic [23:0]     rem,
   output step_result_type result
);

   logic        less;
   logic [23:0] cyc_wide;

   assign cyc_wide        = {16'd0, cyc};
   assign less            = cyc_wide < rem;
   assign result.rem_next = less ? (rem - cyc_wide) : 24'd0;
   assign result.cyc_next = less ? 8'd0 : (cyc - rem[7:0]);
   assign result.gap_done = !less;

endmodule

>>> rtl/tpp_gap_queue.sv
// ----------------------------------------------------------------------------
// Tape pulse player gap queue
// Circular buffer of decoded gaps with a registered head read.
// ----------------------------------------------------------------------------
module tpp_gap_queue import tpp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [23:0]      push_data,
   input  logic             pop,
   input  logic             clear,
   output logic [23:0]      head_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [23:0]      mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [23:0]      head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else begin
         if (push) begin
            wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_in = count_ff + 1'b1;
         end else if (pop && !push) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !clear) begin
         mem[wr_ptr_ff] <= push_data;
      end
      head_ff <= mem[rd_ptr_ff];
   end

   assign head_data    = head_ff;
   assign status.full  = count_ff == FULL_CNT;
   assign status.empty = count_ff == '0;

endmodule
